FILE: sv/assert_macros.svh
// assertion macros for the rtalu block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: sv/rtalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtalu_pkg
// types and codes shared by the rational time alu
// ----------------------------------------------------------------------------
package rtalu_pkg;
	localparam int VALUE_BITS_DEF = 63;

	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,
		OP_CMP    = 2'd1,
		OP_ADD    = 2'd2,
		OP_SUB    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NEGATIVE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ORD_LESS    = 2'd0,
		ORD_EQUAL   = 2'd1,
		ORD_GREATER = 2'd2
	} order_t;

	// command to the shared divide unit
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_GA_DIV,
		S_GA_WAIT,
		S_RA_DIV,
		S_RA_WAIT,
		S_GB_DIV,
		S_GB_WAIT,
		S_RB_DIV,
		S_RB_WAIT,
		S_CMP_A,
		S_CMP_AW,
		S_CMP_C,
		S_CMP_CW,
		S_CMP_EVAL,
		S_GG_DIV,
		S_GG_WAIT,
		S_FAC_DIV,
		S_FAC_WAIT,
		S_MUL,
		S_MUL_WAIT,
		S_SUM,
		S_GR_DIV,
		S_GR_WAIT,
		S_RR_DIV,
		S_RR_WAIT,
		S_OUT
	} state_t;
endpackage

FILE: sv/rtalu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtalu_req_if / rtalu_res_if
// valid/ready channels for the rational time alu
// ----------------------------------------------------------------------------
interface rtalu_req_if #(parameter int VALUE_BITS = rtalu_pkg::VALUE_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [VALUE_BITS-1:0] a_value;
	logic [VALUE_BITS-1:0] a_rate;
	logic [VALUE_BITS-1:0] b_value;
	logic [VALUE_BITS-1:0] b_rate;
	modport source (output valid, req_type, a_value, a_rate, b_value, b_rate, input ready);
	modport sink (input valid, req_type, a_value, a_rate, b_value, b_rate, output ready);
endinterface

interface rtalu_res_if #(parameter int VALUE_BITS = rtalu_pkg::VALUE_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] res_value;
	logic [VALUE_BITS-1:0] res_rate;
	logic [1:0]            order;
	logic [1:0]            status;
	modport source (output valid, res_value, res_rate, order, status, input ready);
	modport sink (input valid, res_value, res_rate, order, status, output ready);
endinterface

FILE: sv/rtalu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtalu_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtalu_div #(
	parameter int W = rtalu_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rtalu_pkg::div_ctl_t ctl,
	input  logic [W-1:0]        dividend,
	input  logic [W-1:0]        divisor,
	output rtalu_pkg::div_sts_t sts,
	output logic [W-1:0]        quot,
	output logic [W-1:0]        rem
);
	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quo_q;
	assign rem      = rem_q;
endmodule

FILE: sv/rational_time_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_time_alu_unit
// reduce, compare, add and subtract of rational times on one shared divider
// ----------------------------------------------------------------------------
// channel  dir  fields
// req      in   req_type, a_value, a_rate, b_value, b_rate
// res      out  res_value, res_rate, order, status
//
// every gcd and quotient step is one division, and every continued fraction step
// two, on a shared restoring divider; each of the three products runs on a
// shift-add multiplier. an invalid operand goes from the check state straight
// to the output state; a subtract runs four euclid chains and one continued
// fraction expansion.
// reset clears the sequencer and the output valid; req is ready only idle.
// the result word holds until taken.
`include "assert_macros.svh"
module rational_time_alu_unit #(
	parameter int VALUE_BITS = rtalu_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rtalu_req_if.sink   req,
	rtalu_res_if.source res
);
	localparam int W  = VALUE_BITS;
	localparam int CW = $clog2(W + 1);

	rtalu_pkg::state_t state_q, state_d;

	logic [1:0]   op_q;
	logic [W-1:0] av_q, ar_q, bv_q, br_q;
	logic [W-1:0] x_q, y_q, g_q;       // euclid pair and held gcd
	logic [W-1:0] ca_q, cb_q, cc_q, cd_q, qa_q, ra_q;
	logic         flip_q;
	logic [W-1:0] fa_q, fb_q;          // br/g and ar/g
	logic [1:0]   mcnt_q;
	logic [W-1:0] left_q, right_q, rate_q;
	logic         ovf_q;
	logic [W-1:0] rv_q, rr_q;
	logic [1:0]   ord_q, st_q;
	logic         ovalid_q;

	rtalu_pkg::div_ctl_t dctl;
	rtalu_pkg::div_sts_t dsts;
	logic [W-1:0] dn, dd, dq, dr;

	rtalu_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .dividend(dn), .divisor(dd),
		.sts(dsts), .quot(dq), .rem(dr)
	);

	// shift-add multiplier, msb of the multiplier first, one bit per cycle
	// a product past W bits sets the sticky overflow
	logic [W-1:0]  mx, my;
	logic [W-1:0]  mul_x_q, mul_y_q, mul_acc_q;
	logic [CW-1:0] mul_cnt_q;
	logic [W:0]    mul_sum;
	logic          mul_ovf;
	always_comb begin
		unique case (mcnt_q)
			2'd0:    begin mx = av_q; my = fa_q; end
			2'd1:    begin mx = bv_q; my = fb_q; end
			default: begin mx = ar_q; my = fa_q; end
		endcase
	end

	assign mul_sum = {1'b0, mul_acc_q[W-2:0], 1'b0}
		+ (mul_y_q[W-1] ? {1'b0, mul_x_q} : {(W+1){1'b0}});
	assign mul_ovf = mul_acc_q[W-1] | mul_sum[W];

	logic [W:0] wide_sum;
	logic       sum_ovf;
	assign wide_sum = {1'b0, left_q} + {1'b0, right_q};
	assign sum_ovf  = (op_q == rtalu_pkg::OP_ADD) && wide_sum[W];

	function automatic logic cmp_less(input logic [W-1:0] qa, input logic [W-1:0] qc,
		input logic [W-1:0] ra, input logic [W-1:0] rc, input logic fl);
		if (qa != qc) return (qa < qc) != fl;
		return (ra == '0) != fl;
	endfunction

	always_comb begin
		state_d   = state_q;
		dctl.start = 1'b0;
		dn = x_q;
		dd = y_q;
		unique case (state_q)
			rtalu_pkg::S_IDLE:  if (req.valid && req.ready) state_d = rtalu_pkg::S_CHECK;
			rtalu_pkg::S_CHECK: begin
				if (ar_q == '0 || (op_q != rtalu_pkg::OP_REDUCE && br_q == '0))
					state_d = rtalu_pkg::S_OUT;
				else
					state_d = rtalu_pkg::S_GA_DIV;
			end
			rtalu_pkg::S_GA_DIV, rtalu_pkg::S_GB_DIV, rtalu_pkg::S_GG_DIV,
			rtalu_pkg::S_GR_DIV: begin
				if (y_q == '0) begin
					unique case (state_q)
						rtalu_pkg::S_GA_DIV: state_d = rtalu_pkg::S_RA_DIV;
						rtalu_pkg::S_GB_DIV: state_d = rtalu_pkg::S_RB_DIV;
						rtalu_pkg::S_GG_DIV: state_d = rtalu_pkg::S_FAC_DIV;
						default:             state_d = rtalu_pkg::S_RR_DIV;
					endcase
				end else begin
					dctl.start = 1'b1;
					state_d = rtalu_pkg::state_t'(state_q + 5'd1);
				end
			end
			rtalu_pkg::S_GA_WAIT, rtalu_pkg::S_GB_WAIT, rtalu_pkg::S_GG_WAIT,
			rtalu_pkg::S_GR_WAIT: begin
				if (dsts.done) state_d = rtalu_pkg::state_t'(state_q - 5'd1);
			end
			rtalu_pkg::S_RA_DIV, rtalu_pkg::S_RB_DIV, rtalu_pkg::S_RR_DIV: begin
				// divide value then rate by g, mcnt selects
				dctl.start = 1'b1;
				dd = g_q;
				unique case (state_q)
					rtalu_pkg::S_RA_DIV: dn = mcnt_q[0] ? ar_q : av_q;
					rtalu_pkg::S_RB_DIV: dn = mcnt_q[0] ? br_q : bv_q;
					default:             dn = mcnt_q[0] ? rr_q : rv_q;
				endcase
				state_d = rtalu_pkg::state_t'(state_q + 5'd1);
			end
			rtalu_pkg::S_RA_WAIT, rtalu_pkg::S_RB_WAIT, rtalu_pkg::S_RR_WAIT: begin
				if (dsts.done) begin
					if (!mcnt_q[0]) state_d = rtalu_pkg::state_t'(state_q - 5'd1);
					else begin
						unique case (state_q)
							rtalu_pkg::S_RA_WAIT: state_d =
								(op_q == rtalu_pkg::OP_REDUCE) ? rtalu_pkg::S_OUT
								: rtalu_pkg::S_GB_DIV;
							rtalu_pkg::S_RB_WAIT: state_d =
								(op_q == rtalu_pkg::OP_ADD) ? rtalu_pkg::S_GG_DIV
								: rtalu_pkg::S_CMP_A;
							default: state_d = rtalu_pkg::S_OUT;
						endcase
					end
				end
			end
			rtalu_pkg::S_CMP_A: begin
				dctl.start = 1'b1; dn = ca_q; dd = cb_q;
				state_d = rtalu_pkg::S_CMP_AW;
			end
			rtalu_pkg::S_CMP_AW: if (dsts.done) state_d = rtalu_pkg::S_CMP_C;
			rtalu_pkg::S_CMP_C: begin
				dctl.start = 1'b1; dn = cc_q; dd = cd_q;
				state_d = rtalu_pkg::S_CMP_CW;
			end
			rtalu_pkg::S_CMP_CW: if (dsts.done) state_d = rtalu_pkg::S_CMP_EVAL;
			rtalu_pkg::S_CMP_EVAL: begin
				if (qa_q != dq || ra_q == '0 || dr == '0) begin
					// equal operands subtract to zero
					if (op_q == rtalu_pkg::OP_SUB && (!cmp_less(qa_q, dq, ra_q, dr, flip_q)
						|| (qa_q == dq && ra_q == dr)))
						state_d = rtalu_pkg::S_GG_DIV;
					else
						state_d = rtalu_pkg::S_OUT;
				end else state_d = rtalu_pkg::S_CMP_A;
			end
			rtalu_pkg::S_FAC_DIV: begin
				dctl.start = 1'b1; dd = g_q;
				dn = mcnt_q[0] ? ar_q : br_q;
				state_d = rtalu_pkg::S_FAC_WAIT;
			end
			rtalu_pkg::S_FAC_WAIT: begin
				if (dsts.done)
					state_d = mcnt_q[0] ? rtalu_pkg::S_MUL : rtalu_pkg::S_FAC_DIV;
			end
			rtalu_pkg::S_MUL:      state_d = rtalu_pkg::S_MUL_WAIT;
			rtalu_pkg::S_MUL_WAIT: begin
				if (mul_cnt_q == CW'(1))
					state_d = (mcnt_q == 2'd2) ? rtalu_pkg::S_SUM : rtalu_pkg::S_MUL;
			end
			rtalu_pkg::S_SUM:  state_d = ovf_q || sum_ovf ? rtalu_pkg::S_OUT
				: rtalu_pkg::S_GR_DIV;
			rtalu_pkg::S_OUT:  if (ovalid_q && res.ready) state_d = rtalu_pkg::S_IDLE;
			default:           state_d = rtalu_pkg::S_IDLE;
		endcase
	end

	assign req.ready = (state_q == rtalu_pkg::S_IDLE) && !ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rtalu_pkg::S_IDLE;
			ovalid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			if (state_q == rtalu_pkg::S_OUT && !ovalid_q) ovalid_q <= 1'b1;
			else if (res.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rtalu_pkg::S_IDLE: begin
				op_q <= req.req_type;
				av_q <= req.a_value; ar_q <= req.a_rate;
				bv_q <= req.b_value; br_q <= req.b_rate;
				rv_q <= '0; rr_q <= '0; ord_q <= rtalu_pkg::ORD_LESS;
				st_q <= rtalu_pkg::ST_OK; ovf_q <= 1'b0;
				mcnt_q <= '0; flip_q <= 1'b0;
			end
			rtalu_pkg::S_CHECK: begin
				if (ar_q == '0 || (op_q != rtalu_pkg::OP_REDUCE && br_q == '0))
					st_q <= rtalu_pkg::ST_INVALID;
				x_q <= av_q; y_q <= ar_q;
			end
			rtalu_pkg::S_GA_DIV, rtalu_pkg::S_GB_DIV, rtalu_pkg::S_GG_DIV,
			rtalu_pkg::S_GR_DIV: begin
				if (y_q == '0) begin g_q <= x_q; mcnt_q <= '0; end
			end
			rtalu_pkg::S_GA_WAIT, rtalu_pkg::S_GB_WAIT, rtalu_pkg::S_GG_WAIT,
			rtalu_pkg::S_GR_WAIT: begin
				if (dsts.done) begin x_q <= y_q; y_q <= dr; end
			end
			rtalu_pkg::S_RA_WAIT, rtalu_pkg::S_RB_WAIT, rtalu_pkg::S_RR_WAIT: begin
				if (dsts.done) begin
					mcnt_q <= mcnt_q + 2'd1;
					unique case (state_q)
						rtalu_pkg::S_RA_WAIT: begin
							if (mcnt_q[0]) begin
								ar_q <= dq;
								if (op_q == rtalu_pkg::OP_REDUCE) begin
									rv_q <= av_q; rr_q <= dq;
								end
								x_q <= bv_q; y_q <= br_q;
							end else av_q <= dq;
						end
						rtalu_pkg::S_RB_WAIT: begin
							if (mcnt_q[0]) begin
								br_q <= dq;
								ca_q <= av_q; cb_q <= ar_q; cc_q <= bv_q; cd_q <= dq;
								x_q <= ar_q; y_q <= dq;
							end else bv_q <= dq;
						end
						default: begin
							if (mcnt_q[0]) rr_q <= dq; else rv_q <= dq;
						end
					endcase
				end
			end
			rtalu_pkg::S_CMP_AW: if (dsts.done) begin qa_q <= dq; ra_q <= dr; end
			rtalu_pkg::S_CMP_EVAL: begin
				if (qa_q != dq || ra_q == '0 || dr == '0) begin
					if (op_q == rtalu_pkg::OP_CMP) begin
						if (qa_q == dq && ra_q == dr) ord_q <= rtalu_pkg::ORD_EQUAL;
						else ord_q <= cmp_less(qa_q, dq, ra_q, dr, flip_q)
							? rtalu_pkg::ORD_LESS : rtalu_pkg::ORD_GREATER;
					end else if (cmp_less(qa_q, dq, ra_q, dr, flip_q)
						&& !(qa_q == dq && ra_q == dr))
						st_q <= rtalu_pkg::ST_NEGATIVE;
					mcnt_q <= '0;
				end else begin
					ca_q <= cb_q; cb_q <= ra_q; cc_q <= cd_q; cd_q <= dr;
					flip_q <= !flip_q;
				end
			end
			rtalu_pkg::S_FAC_WAIT: begin
				if (dsts.done) begin
					if (mcnt_q[0]) begin fb_q <= dq; mcnt_q <= '0; end
					else begin fa_q <= dq; mcnt_q <= 2'd1; end
				end
			end
			rtalu_pkg::S_MUL: begin
				mul_x_q   <= mx;
				mul_y_q   <= my;
				mul_acc_q <= '0;
				mul_cnt_q <= CW'(W);
			end
			rtalu_pkg::S_MUL_WAIT: begin
				mul_acc_q <= mul_sum[W-1:0];
				mul_y_q   <= {mul_y_q[W-2:0], 1'b0};
				mul_cnt_q <= mul_cnt_q - 1'b1;
				if (mul_ovf) ovf_q <= 1'b1;
				if (mul_cnt_q == CW'(1)) begin
					unique case (mcnt_q)
						2'd0:    left_q  <= mul_sum[W-1:0];
						2'd1:    right_q <= mul_sum[W-1:0];
						default: rate_q  <= mul_sum[W-1:0];
					endcase
					mcnt_q <= mcnt_q + 2'd1;
				end
			end
			rtalu_pkg::S_SUM: begin
				if (ovf_q || sum_ovf) st_q <= rtalu_pkg::ST_OVERFLOW;
				else begin
					rv_q <= (op_q == rtalu_pkg::OP_ADD) ? wide_sum[W-1:0]
						: left_q - right_q;
					rr_q <= rate_q;
					x_q  <= (op_q == rtalu_pkg::OP_ADD) ? wide_sum[W-1:0]
						: left_q - right_q;
					y_q  <= rate_q;
				end
				mcnt_q <= '0;
			end
			default: ;
		endcase
	end

	assign res.valid     = ovalid_q;
	assign res.res_value = (st_q == rtalu_pkg::ST_OK) ? rv_q : '0;
	assign res.res_rate  = (st_q == rtalu_pkg::ST_OK) ? rr_q : '0;
	assign res.order     = (st_q == rtalu_pkg::ST_OK) ? ord_q : rtalu_pkg::ORD_LESS;
	assign res.status    = st_q;

	`ASSERT_NEVER(a_ready_busy, clk, arst_n, req.ready && dsts.busy, "ready while dividing")
	`ASSERT_NEVER(a_err_payload, clk, arst_n,
		res.valid && res.status != rtalu_pkg::ST_OK && res.res_rate != '0, "error with rate")
	`ASSERT_NEVER(a_ok_rate, clk, arst_n,
		res.valid && res.status == rtalu_pkg::ST_OK && op_q != rtalu_pkg::OP_CMP
		&& res.res_rate == '0, "zero rate")
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for rational_time_alu_unit: a directed table of
// corner words followed by random reduce/compare/add/subtract words, every
// result checked in order against its tabled value or a bit-exact rational arithmetic predictor
// ----------------------------------------------------------------------------
module tb_top;
	localparam int VB = rtalu_pkg::VALUE_BITS_DEF;
	localparam longint unsigned MAXV = 64'h7fff_ffff_ffff_ffff;
	localparam int N_RANDOM = 1530;
	localparam int STALL_LIMIT = 400000;

	typedef struct packed {
		logic [VB-1:0]       value;
		logic [VB-1:0]       rate;
		rtalu_pkg::order_t   order;
		rtalu_pkg::status_t  status;
	} rt_result_t;

	typedef struct {
		rtalu_pkg::op_t op;
		logic [VB-1:0]  av, ar, bv, br;
		bit             typed;
		rt_result_t     want;
	} rt_word_t;

	logic clk;
	logic arst_n;

	rtalu_req_if req_ch ();
	rtalu_res_if res_ch ();

	rational_time_alu_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	rt_word_t   stim[$];
	rt_result_t expected_q[$];
	int         cur;
	int         errors;
	bit         calm;
	bit         hold_res;
	bit         sending_done;
	int         quiet_cycles;

	// ---- predictor ---------------------------------------------------------
	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic bit mul_fits(longint unsigned x, longint unsigned y,
		output longint unsigned p);
		p = 0;
		if (x != 0 && y > MAXV / x)
			return 0;
		p = x * y;
		return 1;
	endfunction

	// exact order via continued fraction expansion
	function automatic rtalu_pkg::order_t cf_order(longint unsigned a, longint unsigned b,
		longint unsigned c, longint unsigned d);
		bit flip;
		longint unsigned qa, qc, ra, rc;
		flip = 0;
		forever begin
			qa = a / b;
			qc = c / d;
			if (qa != qc)
				return ((qa < qc) != flip) ? rtalu_pkg::ORD_LESS : rtalu_pkg::ORD_GREATER;
			ra = a % b;
			rc = c % d;
			if (ra == 0 || rc == 0) begin
				if (ra == rc)
					return rtalu_pkg::ORD_EQUAL;
				return ((ra == 0) != flip) ? rtalu_pkg::ORD_LESS : rtalu_pkg::ORD_GREATER;
			end
			a = b;
			b = ra;
			c = d;
			d = rc;
			flip = !flip;
		end
	endfunction

	function automatic rt_result_t rational_result(rt_word_t w);
		rt_result_t r;
		longint unsigned av, ar, bv, br, g, left, right, rate, rv, rr;
		r = '{value: '0, rate: '0, order: rtalu_pkg::ORD_LESS, status: rtalu_pkg::ST_OK};
		av = 64'(w.av);
		ar = 64'(w.ar);
		bv = 64'(w.bv);
		br = 64'(w.br);
		if (ar == 0 || (w.op != rtalu_pkg::OP_REDUCE && br == 0)) begin
			r.status = rtalu_pkg::ST_INVALID;
			return r;
		end
		g = gcd64(av, ar);
		av = av / g;
		ar = ar / g;
		if (w.op == rtalu_pkg::OP_REDUCE) begin
			r.value = VB'(av);
			r.rate = VB'(ar);
			return r;
		end
		g = gcd64(bv, br);
		bv = bv / g;
		br = br / g;
		if (w.op == rtalu_pkg::OP_CMP) begin
			r.order = cf_order(av, ar, bv, br);
			return r;
		end
		if (w.op == rtalu_pkg::OP_SUB && cf_order(av, ar, bv, br) == rtalu_pkg::ORD_LESS) begin
			r.status = rtalu_pkg::ST_NEGATIVE;
			return r;
		end
		g = gcd64(ar, br);
		if (!mul_fits(av, br / g, left) || !mul_fits(bv, ar / g, right))
			r.status = rtalu_pkg::ST_OVERFLOW;
		else if (w.op == rtalu_pkg::OP_ADD && right > MAXV - left)
			r.status = rtalu_pkg::ST_OVERFLOW;
		else if (!mul_fits(ar, br / g, rate))
			r.status = rtalu_pkg::ST_OVERFLOW;
		else begin
			rv = (w.op == rtalu_pkg::OP_ADD) ? left + right : left - right;
			rr = rate;
			g = gcd64(rv, rr);
			r.value = VB'(rv / g);
			r.rate = VB'(rr / g);
		end
		return r;
	endfunction

	// ---- stimulus ----------------------------------------------------------
	task automatic add_word(rtalu_pkg::op_t op, longint unsigned av, longint unsigned ar,
		longint unsigned bv, longint unsigned br, bit typed = 0,
		longint unsigned wv = 0, longint unsigned wr = 0,
		rtalu_pkg::order_t wo = rtalu_pkg::ORD_LESS,
		rtalu_pkg::status_t ws = rtalu_pkg::ST_OK);
		rt_word_t w;
		w.op = op;
		w.av = VB'(av);
		w.ar = VB'(ar);
		w.bv = VB'(bv);
		w.br = VB'(br);
		w.typed = typed;
		w.want = '{value: VB'(wv), rate: VB'(wr), order: wo, status: ws};
		stim.push_back(w);
	endtask

	function automatic longint unsigned rnd_num();
		longint unsigned full;
		full = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return full & MAXV;
			1: return $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 1 : MAXV);
			2, 3: return full & 64'hfffff;
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	task automatic build_stimulus();
		rtalu_pkg::op_t op;
		longint unsigned av, ar, k;
		// directed table
		add_word(rtalu_pkg::OP_REDUCE, 0, 5, 0, 0, 1, 0, 1);
		add_word(rtalu_pkg::OP_REDUCE, 6, 4, 7, 0, 1, 3, 2);
		add_word(rtalu_pkg::OP_REDUCE, MAXV, MAXV, MAXV, MAXV, 1, 1, 1);
		add_word(rtalu_pkg::OP_REDUCE, MAXV, 1, 0, 0, 1, MAXV, 1);
		add_word(rtalu_pkg::OP_REDUCE, 3, 0, 1, 1, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_INVALID);
		add_word(rtalu_pkg::OP_CMP, 1, 2, 1, 0, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_INVALID);
		add_word(rtalu_pkg::OP_ADD, 1, 0, 1, 2, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_INVALID);
		add_word(rtalu_pkg::OP_SUB, 1, 2, 1, 0, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_INVALID);
		add_word(rtalu_pkg::OP_CMP, 2, 4, 1, 2, 1, 0, 0,
			rtalu_pkg::ORD_EQUAL, rtalu_pkg::ST_OK);
		add_word(rtalu_pkg::OP_CMP, 1, 3, 1, 2, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_OK);
		add_word(rtalu_pkg::OP_CMP, 1, 2, 1, 3, 1, 0, 0,
			rtalu_pkg::ORD_GREATER, rtalu_pkg::ST_OK);
		add_word(rtalu_pkg::OP_CMP, 0, 7, 0, 9, 1, 0, 0,
			rtalu_pkg::ORD_EQUAL, rtalu_pkg::ST_OK);
		add_word(rtalu_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6);
		add_word(rtalu_pkg::OP_SUB, 1, 2, 1, 3, 1, 1, 6);
		add_word(rtalu_pkg::OP_SUB, 1, 3, 1, 2, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_NEGATIVE);
		add_word(rtalu_pkg::OP_SUB, 5, 7, 10, 14, 1, 0, 1);
		add_word(rtalu_pkg::OP_SUB, 2, 1, 2, 1, 1, 0, 1);
		add_word(rtalu_pkg::OP_ADD, MAXV, 1, 1, 1, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_OVERFLOW);
		add_word(rtalu_pkg::OP_ADD, MAXV, 1, 1, 2, 1, 0, 0,
			rtalu_pkg::ORD_LESS, rtalu_pkg::ST_OVERFLOW);
		add_word(rtalu_pkg::OP_SUB, MAXV, 1, 0, MAXV, 1, MAXV, 1);
		add_word(rtalu_pkg::OP_ADD, 1, MAXV, 1, MAXV - 1);
		add_word(rtalu_pkg::OP_CMP, MAXV, MAXV - 1, MAXV - 1, MAXV - 2);
		add_word(rtalu_pkg::OP_SUB, MAXV, MAXV - 1, MAXV - 1, MAXV - 2);
		add_word(rtalu_pkg::OP_ADD, 0, MAXV, 0, 1);
		// random words: mostly small magnitudes, some full width, some equal pairs
		repeat (N_RANDOM) begin
			op = rtalu_pkg::op_t'($urandom_range(3));
			av = rnd_num();
			ar = rnd_num();
			if ($urandom_range(6) == 0) begin
				k = $urandom_range(1, 40);
				add_word(op, av, ar, (av * k) & MAXV, (ar * k) & MAXV);
			end else
				add_word(op, av, ar, rnd_num(), rnd_num());
		end
	endtask

	// ---- clock and reset ---------------------------------------------------
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// ---- request driver ----------------------------------------------------
	initial begin
		errors = 0;
		cur = 0;
		calm = 0;
		sending_done = 0;
		req_ch.valid = 0;
		req_ch.req_type = '0;
		req_ch.a_value = '0;
		req_ch.a_rate = '0;
		req_ch.b_value = '0;
		req_ch.b_rate = '0;
		build_stimulus();
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int i = 0; i < stim.size(); i++) begin
			calm <= (i >= 600 && i < 800);
			req_ch.valid <= 1;
			req_ch.req_type <= stim[i].op;
			req_ch.a_value <= stim[i].av;
			req_ch.a_rate <= stim[i].ar;
			req_ch.b_value <= stim[i].bv;
			req_ch.b_rate <= stim[i].br;
			cur <= i;
			do @(posedge clk); while (!req_ch.ready);
			if (!calm && $urandom_range(99) < 34) begin
				req_ch.valid <= 0;
				do @(posedge clk); while ($urandom_range(99) < 34);
			end
		end
		req_ch.valid <= 0;
		sending_done <= 1;
	end

	// ---- result ready, with one long hold-off ------------------------------
	initial begin
		hold_res = 0;
		wait (cur == 100);
		hold_res = 1;
		repeat (3000) @(posedge clk);
		hold_res = 0;
	end

	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 0;
		else
			res_ch.ready <= !hold_res && (calm || $urandom_range(99) >= 34);
	end

	// ---- monitors ----------------------------------------------------------
	always @(posedge clk) begin
		rt_result_t got, want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_q.push_back(stim[cur].typed ? stim[cur].want
					: rational_result(stim[cur]));
			if (res_ch.valid && res_ch.ready) begin
				got.value = res_ch.res_value;
				got.rate = res_ch.res_rate;
				got.order = rtalu_pkg::order_t'(res_ch.order);
				got.status = rtalu_pkg::status_t'(res_ch.status);
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word value=%0d rate=%0d", $time,
						got.value, got.rate);
				end else begin
					want = expected_q.pop_front();
					if (got.value !== want.value) begin
						errors++;
						$display("%0t: res_value expected %0d actual %0d", $time,
							want.value, got.value);
					end
					if (got.rate !== want.rate) begin
						errors++;
						$display("%0t: res_rate expected %0d actual %0d", $time,
							want.rate, got.rate);
					end
					if (got.order !== want.order) begin
						errors++;
						$display("%0t: order expected %0d actual %0d", $time,
							want.order, got.order);
					end
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
					end
				end
			end
		end
	end

	// ---- watchdog ----------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---- end of run --------------------------------------------------------
	initial begin
		wait (sending_done === 1'b1);
		wait (expected_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
